@@ rtl/nlef_pkg.sv @@
// Package for the nearest live entry finder: codes, item types, control bundles.
`default_nettype none
package nlef_pkg;
	localparam int ENTRIES_DEF    = 128;
	localparam int COORD_BITS_DEF = 24;
	localparam int RANGE_SQ_W     = 48;

	localparam logic [1:0] OP_REGISTER = 2'd0;
	localparam logic [1:0] OP_ALIVE    = 2'd1;
	localparam logic [1:0] OP_QUERY    = 2'd2;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_NOSLOT = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [6:0]         slot;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic [7:0]         area_id;
		logic               alive_flag;
		logic               check_area;
		logic               use_range;
		logic [23:0]        min_range;
		logic [23:0]        max_range;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [6:0]  entry_index;
		logic [51:0] best_dist_sq;
	} out_item_t;

	// Ring control shared by every cell
	typedef struct packed {
		logic shift;
		logic app_en;
		logic alive_en;
		logic alive_val;
	} cell_ctl_t;

	// Query filter settings for the distance unit
	typedef struct packed {
		logic filt;
		logic use_range;
	} qctl_t;
endpackage
`default_nettype wire

@@ rtl/nearest_live_entry_finder_top.sv @@
// Top level of the nearest live entry finder: entry ring, sequencer, result register.
//
// Entries live in a ring of ENTRIES cells. For a register or alive-flag item
// the result is built when the item is taken, moves to the output register
// from the done state once that register is free, and the next item can be
// taken after that. A nearest query rotates the whole ring once through a
// single distance pipeline, one entry per cycle, then drains the pipeline
// before its result moves out the same way. One item is worked at a time; a
// finished result waits in the output register while the next item is taken.
`default_nettype none
module nearest_live_entry_finder_top #(
	parameter int ENTRIES    = nlef_pkg::ENTRIES_DEF,
	parameter int COORD_BITS = nlef_pkg::COORD_BITS_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  nlef_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output nlef_pkg::out_item_t  out_data
);
	localparam int C     = COORD_BITS;
	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int DW    = 2 * C + 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      idx_q;
	logic [1:0]            drain_q;
	logic                  accept;
	nlef_pkg::cell_ctl_t   ctl;
	nlef_pkg::out_item_t   res_q;
	nlef_pkg::out_item_t   out_q;
	logic                  out_valid_q;
	logic                  out_free;
	logic [C-1:0]          qx_q, qy_q, qz_q;
	logic [7:0]            qa_q;
	nlef_pkg::qctl_t       qctl_q;
	logic [nlef_pkg::RANGE_SQ_W-1:0] lo_q, hi_q;
	logic                  found;
	logic [CNT_W-1:0]      best_idx;
	logic [DW-1:0]         best;
	logic                  has_room;
	logic                  slot_ok;

	logic [C-1:0] cx [ENTRIES];
	logic [C-1:0] cy [ENTRIES];
	logic [C-1:0] cz [ENTRIES];
	logic [7:0]   ca [ENTRIES];
	logic         cl [ENTRIES];

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign has_room = (32'(count_q) < 32'(ENTRIES));
	assign slot_ok  = (32'(in_data.slot) < 32'(count_q));

	// Drive ring writes and rotation
	always_comb begin
		ctl.shift     = (state_q == ST_SWEEP);
		ctl.app_en    = accept && in_data.opcode == nlef_pkg::OP_REGISTER && has_room;
		ctl.alive_en  = accept && in_data.opcode == nlef_pkg::OP_ALIVE && slot_ok;
		ctl.alive_val = in_data.alive_flag;
	end

	genvar g;
	generate
		for (g = 0; g < ENTRIES; g++) begin : g_cell
			nlef_cell #(.C(C), .CNT_W(CNT_W), .IDX(g)) u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.count     (count_q),
				.slot      (in_data.slot),
				.new_x     (in_data.pos_x[C-1:0]),
				.new_y     (in_data.pos_y[C-1:0]),
				.new_z     (in_data.pos_z[C-1:0]),
				.new_area  (in_data.area_id),
				.new_alive (in_data.alive_flag),
				.nb_x      (cx[(g + 1) % ENTRIES]),
				.nb_y      (cy[(g + 1) % ENTRIES]),
				.nb_z      (cz[(g + 1) % ENTRIES]),
				.nb_area   (ca[(g + 1) % ENTRIES]),
				.nb_alive  (cl[(g + 1) % ENTRIES]),
				.x         (cx[g]),
				.y         (cy[g]),
				.z         (cz[g]),
				.area      (ca[g]),
				.alive     (cl[g])
			);
		end
	endgenerate

	nlef_dist #(.C(C), .CNT_W(CNT_W), .DW(DW)) u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (accept && in_data.opcode == nlef_pkg::OP_QUERY),
		.v_in     ((state_q == ST_SWEEP) && (idx_q < count_q)),
		.idx_in   (idx_q),
		.ex       (cx[0]),
		.ey       (cy[0]),
		.ez       (cz[0]),
		.ea       (ca[0]),
		.ealive   (cl[0]),
		.qx       (qx_q),
		.qy       (qy_q),
		.qz       (qz_q),
		.qa       (qa_q),
		.qctl     (qctl_q),
		.lo       (lo_q),
		.hi       (hi_q),
		.found    (found),
		.best_idx (best_idx),
		.best     (best)
	);

	// Latch query point and squared range bounds
	always_ff @(posedge clk) begin
		if (accept && in_data.opcode == nlef_pkg::OP_QUERY) begin
			qx_q           <= in_data.pos_x[C-1:0];
			qy_q           <= in_data.pos_y[C-1:0];
			qz_q           <= in_data.pos_z[C-1:0];
			qa_q           <= in_data.area_id;
			qctl_q.filt    <= in_data.check_area && in_data.area_id != 8'd0;
			qctl_q.use_range <= in_data.use_range;
			lo_q <= nlef_pkg::RANGE_SQ_W'(in_data.min_range) *
				nlef_pkg::RANGE_SQ_W'(in_data.min_range);
			hi_q <= nlef_pkg::RANGE_SQ_W'(in_data.max_range) *
				nlef_pkg::RANGE_SQ_W'(in_data.max_range);
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			drain_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.opcode == nlef_pkg::OP_QUERY) begin
							idx_q   <= '0;
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_DONE;
						end
						if (ctl.app_en)
							count_q <= count_q + 1'b1;
					end
				end
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == CNT_W'(ENTRIES - 1)) begin
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (drain_q == 2'd3)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Build the pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.found        <= 1'b0;
			res_q.best_dist_sq <= '0;
			res_q.status       <= nlef_pkg::STATUS_OK;
			res_q.entry_index  <= '0;
			case (in_data.opcode)
				nlef_pkg::OP_REGISTER: begin
					if (has_room)
						res_q.entry_index <= 7'(count_q);
					else
						res_q.status <= nlef_pkg::STATUS_FULL;
				end
				nlef_pkg::OP_ALIVE: begin
					res_q.entry_index <= in_data.slot;
					if (!slot_ok)
						res_q.status <= nlef_pkg::STATUS_NOSLOT;
				end
				default: ;
			endcase
		end else if (state_q == ST_DRAIN && drain_q == 2'd3) begin
			res_q.status       <= nlef_pkg::STATUS_OK;
			res_q.found        <= found;
			res_q.entry_index  <= found ? 7'(best_idx) : 7'd0;
			res_q.best_dist_sq <= found ? 52'(best) : 52'd0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == ST_DONE && out_free)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free)
			out_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(ENTRIES))
		else $error("entry count beyond table size");
	a_query_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.opcode == nlef_pkg::OP_QUERY |=> state_q == ST_SWEEP)
		else $error("query did not start a sweep");
	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !out_valid_q |=> out_valid_q && state_q == ST_IDLE)
		else $error("pending result not moved to output");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SWEEP |-> !accept && ctl.shift)
		else $error("item taken during sweep");
endmodule
`default_nettype wire

@@ rtl/nlef_cell.sv @@
// One ring cell: holds a single table entry and passes it to its neighbor on a shift.
`default_nettype none
module nlef_cell #(
	parameter int C     = nlef_pkg::COORD_BITS_DEF,
	parameter int CNT_W = 8,
	parameter int IDX   = 0
) (
	input  wire                     clk,
	input  nlef_pkg::cell_ctl_t     ctl,
	input  wire [CNT_W-1:0]         count,
	input  wire [6:0]               slot,
	input  wire [C-1:0]             new_x,
	input  wire [C-1:0]             new_y,
	input  wire [C-1:0]             new_z,
	input  wire [7:0]               new_area,
	input  wire                     new_alive,
	input  wire [C-1:0]             nb_x,
	input  wire [C-1:0]             nb_y,
	input  wire [C-1:0]             nb_z,
	input  wire [7:0]               nb_area,
	input  wire                     nb_alive,
	output logic [C-1:0]            x,
	output logic [C-1:0]            y,
	output logic [C-1:0]            z,
	output logic [7:0]              area,
	output logic                    alive
);
	logic [C-1:0] x_q, y_q, z_q;
	logic [7:0]   area_q;
	logic         alive_q;

	// Rotate, append at the fill point, or rewrite the alive flag
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			x_q     <= nb_x;
			y_q     <= nb_y;
			z_q     <= nb_z;
			area_q  <= nb_area;
			alive_q <= nb_alive;
		end else if (ctl.app_en && count == CNT_W'(IDX)) begin
			x_q     <= new_x;
			y_q     <= new_y;
			z_q     <= new_z;
			area_q  <= new_area;
			alive_q <= new_alive;
		end else if (ctl.alive_en && 32'(slot) == 32'(IDX)) begin
			alive_q <= ctl.alive_val;
		end
	end

	assign x     = x_q;
	assign y     = y_q;
	assign z     = z_q;
	assign area  = area_q;
	assign alive = alive_q;
endmodule
`default_nettype wire

@@ rtl/nlef_dist.sv @@
// Distance pipeline: filter, abs difference, square, sum, and running nearest pick.
`default_nettype none
module nlef_dist #(
	parameter int C     = nlef_pkg::COORD_BITS_DEF,
	parameter int CNT_W = 8,
	parameter int DW    = 2 * C + 2
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  clr,
	input  wire                  v_in,
	input  wire [CNT_W-1:0]      idx_in,
	input  wire [C-1:0]          ex,
	input  wire [C-1:0]          ey,
	input  wire [C-1:0]          ez,
	input  wire [7:0]            ea,
	input  wire                  ealive,
	input  wire [C-1:0]          qx,
	input  wire [C-1:0]          qy,
	input  wire [C-1:0]          qz,
	input  wire [7:0]            qa,
	input  nlef_pkg::qctl_t      qctl,
	input  wire [nlef_pkg::RANGE_SQ_W-1:0] lo,
	input  wire [nlef_pkg::RANGE_SQ_W-1:0] hi,
	output logic                 found,
	output logic [CNT_W-1:0]     best_idx,
	output logic [DW-1:0]        best
);
	localparam int CW = (DW > nlef_pkg::RANGE_SQ_W) ? DW : nlef_pkg::RANGE_SQ_W;

	logic               area_ok, pass;
	logic signed [C:0]  dx, dy, dz;
	logic [C-1:0]       ax_s1, ay_s1, az_s1;
	logic               v_s1, v_s2, v_s3;
	logic [CNT_W-1:0]   idx_s1, idx_s2, idx_s3;
	logic [2*C-1:0]     sx_s2, sy_s2, sz_s2;
	logic [DW-1:0]      sum_s3;
	logic               in_win, better;
	logic               found_q;
	logic [CNT_W-1:0]   best_idx_q;
	logic [DW-1:0]      best_q;

	// Strict rule needs a matching nonzero area; lenient also keeps area none
	always_comb begin
		if (!qctl.filt)
			area_ok = 1'b1;
		else if (qctl.use_range)
			area_ok = (ea == 8'd0) || (ea == qa);
		else
			area_ok = (ea != 8'd0) && (ea == qa);
		pass = v_in && ealive && area_ok;
		dx = $signed({qx[C-1], qx}) - $signed({ex[C-1], ex});
		dy = $signed({qy[C-1], qy}) - $signed({ey[C-1], ey});
		dz = $signed({qz[C-1], qz}) - $signed({ez[C-1], ez});
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= pass;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Magnitude, square, sum
	always_ff @(posedge clk) begin
		ax_s1  <= dx[C] ? C'(-dx) : C'(dx);
		ay_s1  <= dy[C] ? C'(-dy) : C'(dy);
		az_s1  <= dz[C] ? C'(-dz) : C'(dz);
		idx_s1 <= idx_in;
		sx_s2  <= (2*C)'(ax_s1) * (2*C)'(ax_s1);
		sy_s2  <= (2*C)'(ay_s1) * (2*C)'(ay_s1);
		sz_s2  <= (2*C)'(az_s1) * (2*C)'(az_s1);
		idx_s2 <= idx_s1;
		sum_s3 <= DW'(sx_s2) + DW'(sy_s2) + DW'(sz_s2);
		idx_s3 <= idx_s2;
	end

	// Keep a candidate only if strictly nearer, so the lowest index wins ties
	always_comb begin
		in_win = !qctl.use_range || ((CW'(sum_s3) > CW'(lo)) && (CW'(sum_s3) < CW'(hi)));
		better = v_s3 && in_win && (!found_q || sum_s3 < best_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			found_q <= 1'b0;
		else if (clr)
			found_q <= 1'b0;
		else if (better)
			found_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (better) begin
			best_q     <= sum_s3;
			best_idx_q <= idx_s3;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best     = best_q;
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the nearest live entry finder: directed table, then random traffic.
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_ENTRIES = 128;
	localparam int RAND_ITEMS  = 1420;
	localparam int IDLE_LIMIT  = 20000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	nlef_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	nlef_pkg::out_item_t out_data;

	nearest_live_entry_finder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// Shadow copy of the entry table
	logic signed [23:0] tab_x [NUM_ENTRIES];
	logic signed [23:0] tab_y [NUM_ENTRIES];
	logic signed [23:0] tab_z [NUM_ENTRIES];
	logic [7:0] tab_area [NUM_ENTRIES];
	logic tab_alive [NUM_ENTRIES];
	int tab_count;

	nlef_pkg::out_item_t pending_results[$];
	int fail_count;
	int idle_cycles;
	bit stim_done;

	// Directed rows: item, whether a typed-in result applies, and that result
	typedef struct {
		nlef_pkg::in_item_t item;
		bit fixed;
		nlef_pkg::out_item_t result;
	} dir_row_t;
	dir_row_t dir_rows[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [51:0] axis_sq(logic signed [23:0] a, logic signed [23:0] b);
		logic signed [25:0] d;
		logic [25:0] m;
		d = 26'(a) - 26'(b);
		m = d[25] ? 26'(-d) : 26'(d);
		return 52'(m) * 52'(m);
	endfunction

	// Apply one item to the shadow table and return its result
	function automatic nlef_pkg::out_item_t nearest_predict(nlef_pkg::in_item_t it);
		nlef_pkg::out_item_t r;
		logic [51:0] d, lo, hi;
		bit filt;
		r = '0;
		case (it.opcode)
			nlef_pkg::OP_REGISTER: begin
				if (tab_count < NUM_ENTRIES) begin
					tab_x[tab_count] = it.pos_x;
					tab_y[tab_count] = it.pos_y;
					tab_z[tab_count] = it.pos_z;
					tab_area[tab_count] = it.area_id;
					tab_alive[tab_count] = it.alive_flag;
					r.entry_index = 7'(tab_count);
					tab_count++;
				end else begin
					r.status = nlef_pkg::STATUS_FULL;
				end
			end
			nlef_pkg::OP_ALIVE: begin
				r.entry_index = it.slot;
				if (int'(it.slot) < tab_count) tab_alive[it.slot] = it.alive_flag;
				else r.status = nlef_pkg::STATUS_NOSLOT;
			end
			nlef_pkg::OP_QUERY: begin
				filt = it.check_area && it.area_id != 0;
				lo = 52'(it.min_range) * 52'(it.min_range);
				hi = 52'(it.max_range) * 52'(it.max_range);
				for (int i = 0; i < tab_count; i++) begin
					if (!tab_alive[i]) continue;
					if (filt) begin
						if (it.use_range) begin
							if (tab_area[i] != 0 && tab_area[i] != it.area_id) continue;
						end else if (tab_area[i] != it.area_id) begin
							continue;
						end
					end
					d = axis_sq(it.pos_x, tab_x[i]) + axis_sq(it.pos_y, tab_y[i])
						+ axis_sq(it.pos_z, tab_z[i]);
					if (it.use_range && !(d > lo && d < hi)) continue;
					if (!r.found || d < r.best_dist_sq) begin
						r.found = 1'b1;
						r.best_dist_sq = d;
						r.entry_index = 7'(i);
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic nlef_pkg::in_item_t blank_item(logic [1:0] op);
		nlef_pkg::in_item_t it;
		it = '0;
		it.opcode = op;
		return it;
	endfunction

	// Random item; mostly queries, with registrations, alive updates and a few unused opcodes
	function automatic nlef_pkg::in_item_t random_item();
		nlef_pkg::in_item_t it;
		logic [159:0] raw;
		int sel;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
		it = raw[$bits(nlef_pkg::in_item_t)-1:0];
		sel = $urandom_range(0, 99);
		if (sel < 25) it.opcode = nlef_pkg::OP_REGISTER;
		else if (sel < 40) it.opcode = nlef_pkg::OP_ALIVE;
		else if (sel < 97) it.opcode = nlef_pkg::OP_QUERY;
		else it.opcode = OP_UNUSED;
		// keep coordinates clustered so range windows and ties matter
		if ($urandom_range(0, 3) != 0) begin
			it.pos_x = 24'(signed'($urandom_range(0, 64)) - 32);
			it.pos_y = 24'(signed'($urandom_range(0, 64)) - 32);
			it.pos_z = 24'(signed'($urandom_range(0, 64)) - 32);
			it.min_range = 24'($urandom_range(0, 30));
			it.max_range = 24'($urandom_range(0, 120));
		end
		if ($urandom_range(0, 2) != 0) it.area_id = 8'($urandom_range(0, 3));
		if (it.opcode == nlef_pkg::OP_ALIVE && $urandom_range(0, 5) != 0)
			it.slot = 7'($urandom_range(0, tab_count > 0 ? tab_count - 1 : 0));
		return it;
	endfunction

	// Send one item: sometimes a random gap first, then hold until accepted
	task automatic send_item(nlef_pkg::in_item_t it);
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_results.push_back(nearest_predict(it));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		nlef_pkg::in_item_t it;
		nlef_pkg::out_item_t fx;
		dir_row_t row;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		tab_count = 0;
		fail_count = 0;
		stim_done = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table query, update of unregistered slot, unused opcode
		row.fixed = 1; row.item = blank_item(nlef_pkg::OP_QUERY); row.result = '0;
		dir_rows.push_back(row);
		row.item = blank_item(nlef_pkg::OP_ALIVE); row.item.slot = 7'd127;
		fx = '0; fx.status = nlef_pkg::STATUS_NOSLOT; fx.entry_index = 7'd127;
		row.result = fx;
		dir_rows.push_back(row);
		row.item = blank_item(OP_UNUSED); row.item.pos_x = 24'h7FFFFF; row.result = '0;
		dir_rows.push_back(row);
		// register extremes
		row.item = blank_item(nlef_pkg::OP_REGISTER); row.item.pos_x = 24'sh7FFFFF;
		row.item.pos_y = 24'sh800000; row.item.pos_z = 24'sh7FFFFF;
		row.item.area_id = 8'd255; row.item.alive_flag = 1'b1;
		row.result = '0;
		dir_rows.push_back(row);
		row.fixed = 0;
		row.item = blank_item(nlef_pkg::OP_REGISTER); row.item.pos_x = 24'sh800000;
		row.item.pos_y = 24'sh7FFFFF; row.item.pos_z = 24'sh800000;
		row.item.alive_flag = 1'b1; dir_rows.push_back(row);
		row.item = blank_item(nlef_pkg::OP_REGISTER); row.item.area_id = 8'd7;
		row.item.alive_flag = 1'b1; dir_rows.push_back(row);
		row.item = blank_item(nlef_pkg::OP_REGISTER); row.item.area_id = 8'd7;
		row.item.alive_flag = 1'b1; dir_rows.push_back(row);
		row.item = blank_item(nlef_pkg::OP_REGISTER); row.item.pos_x = 24'sd256;
		row.item.alive_flag = 1'b0; dir_rows.push_back(row);
		// farthest query: largest squared distance
		row.item = blank_item(nlef_pkg::OP_QUERY); row.item.pos_x = 24'sh800000;
		row.item.pos_y = 24'sh7FFFFF; row.item.pos_z = 24'sh800000;
		dir_rows.push_back(row);
		row.item.pos_x = 24'sh7FFFFF; row.item.pos_y = 24'sh800000;
		row.item.pos_z = 24'sh7FFFFF; dir_rows.push_back(row);
		// tie at origin, strict and lenient area, range window
		row.item = blank_item(nlef_pkg::OP_QUERY); dir_rows.push_back(row);
		row.item.check_area = 1'b1; row.item.area_id = 8'd7; dir_rows.push_back(row);
		row.item.area_id = 8'd9; dir_rows.push_back(row);
		row.item.use_range = 1'b1; row.item.max_range = 24'hFFFFFF; dir_rows.push_back(row);
		row.item.min_range = 24'hFFFFFF; dir_rows.push_back(row);
		row.item.check_area = 1'b0; row.item.min_range = 24'd0;
		row.item.max_range = 24'd0; dir_rows.push_back(row);
		// alive updates, both values
		row.item = blank_item(nlef_pkg::OP_ALIVE); row.item.slot = 7'd4;
		row.item.alive_flag = 1'b1; dir_rows.push_back(row);
		row.item.slot = 7'd2; row.item.alive_flag = 1'b0; dir_rows.push_back(row);
		row.item = blank_item(nlef_pkg::OP_QUERY); row.item.pos_x = 24'sd200;
		dir_rows.push_back(row);

		// walk the table
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].item);
			if (dir_rows[i].fixed) pending_results[$] = dir_rows[i].result;
		end
		drain_results();

		// random part; fill the table before the end to reach the full case
		for (int n = 0; n < RAND_ITEMS; n++) begin
			it = random_item();
			if (n > RAND_ITEMS - 200 && $urandom_range(0, 1) == 0)
				it.opcode = nlef_pkg::OP_REGISTER;
			send_item(it);
			if (n == RAND_ITEMS / 2) drain_results();
		end
		in_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stall pattern: stretches of free flow and random stalling
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 40) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(50, 300)) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(0, 2) == 0);
			end
		end
	end

	// Compare each accepted result against the oldest expectation
	always @(posedge clk) begin
		nlef_pkg::out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with no expectation: %p", out_data);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_data.status !== exp_r.status) begin
					$error("status exp %0d got %0d", exp_r.status, out_data.status);
					fail_count++;
				end
				if (out_data.found !== exp_r.found) begin
					$error("found exp %0d got %0d", exp_r.found, out_data.found);
					fail_count++;
				end
				if (out_data.entry_index !== exp_r.entry_index) begin
					$error("entry_index exp %0d got %0d", exp_r.entry_index,
						out_data.entry_index);
					fail_count++;
				end
				if (out_data.best_dist_sq !== exp_r.best_dist_sq) begin
					$error("best_dist_sq exp %0d got %0d", exp_r.best_dist_sq,
						out_data.best_dist_sq);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End of run
	initial begin
		idle_cycles = 0;
		fork
			begin
				wait (stim_done);
				while (pending_results.size() != 0) @(posedge clk);
				repeat (200) @(posedge clk);
				if (fail_count == 0 && pending_results.size() == 0)
					$display("ALL CHECKS PASSED");
				else
					$display("CHECKS FAILED");
			end
			begin
				wait (idle_cycles >= IDLE_LIMIT);
				$display("CHECKS FAILED");
			end
		join_any
		$finish;
	end
endmodule
`default_nettype wire
